[sv/hsl_pkg.sv]
// Shared types and constants of the RGB to HSL converter.
// No dependencies; used by every module of the block.
package hsl_pkg;

   localparam int HUE_FRAC_BITS = 6;
   localparam int LEVEL_BITS    = 16;
   localparam int CHAN_W        = 8;
   localparam int HUE_W         = 15;
   localparam int DEN_W         = CHAN_W + 1;
   localparam int DIV_STEPS     = LEVEL_BITS;
   localparam int SAT_NUM_W     = DEN_W + DIV_STEPS;
   localparam int HUE_NUM_W     = 22;

   localparam logic [HUE_W-1:0] SECTOR_UNITS = HUE_W'(60 << HUE_FRAC_BITS);
   localparam logic [HUE_W-1:0] HUE_TWO_U    = HUE_W'(120 << HUE_FRAC_BITS);
   localparam logic [HUE_W-1:0] HUE_THREE_U  = HUE_W'(180 << HUE_FRAC_BITS);
   localparam logic [HUE_W-1:0] HUE_FIVE_U   = HUE_W'(300 << HUE_FRAC_BITS);
   localparam logic [SAT_NUM_W-1:0] SAT_SCALE =
      SAT_NUM_W'(2 * ((1 << LEVEL_BITS) - 1));
   localparam logic [HUE_NUM_W-1:0] HUE_SCALE = HUE_NUM_W'(120 << HUE_FRAC_BITS);

   localparam logic [1:0] SECTOR_RED   = 2'd0;
   localparam logic [1:0] SECTOR_GREEN = 2'd1;
   localparam logic [1:0] SECTOR_BLUE  = 2'd2;

   // Payload of one divider stage: two restoring dividers side by side.
   // The low field holds unused numerator bits above, quotient bits below.
   typedef struct packed {
      logic                  grey;
      logic [1:0]            sector;
      logic [LEVEL_BITS-1:0] light;
      logic [DEN_W-1:0]      sat_den;
      logic [DEN_W-1:0]      sat_rem;
      logic [DIV_STEPS-1:0]  sat_low;
      logic [DEN_W-1:0]      hue_den;
      logic [DEN_W-1:0]      hue_rem;
      logic [DIV_STEPS-1:0]  hue_low;
   } div_type;

endpackage

[sv/hsl_front.sv]
// Front end of the converter: channel extremes, sector, numerators, lightness.
// Two register stages; depends on hsl_pkg.
module hsl_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic [hsl_pkg::CHAN_W-1:0]   red,
   input  logic [hsl_pkg::CHAN_W-1:0]   green,
   input  logic [hsl_pkg::CHAN_W-1:0]   blue,
   output logic                         out_valid,
   output hsl_pkg::div_type             out_data
);
   localparam int CW = hsl_pkg::CHAN_W;
   localparam int DW = hsl_pkg::DEN_W;

   logic [CW-1:0] mx, mn;
   logic [1:0]    sector;
   logic [CW-1:0] pos, neg;

   logic          v1_ff;
   logic [CW-1:0] d1_ff, pos1_ff, neg1_ff;
   logic [DW-1:0] s1_ff;
   logic [1:0]    sec1_ff;

   logic          v2_ff;
   hsl_pkg::div_type data2_ff, data2_in;

   always_comb begin
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      if (red == mx) begin
         sector = hsl_pkg::SECTOR_RED;   pos = green; neg = blue;
      end else if (green == mx) begin
         sector = hsl_pkg::SECTOR_GREEN; pos = blue;  neg = red;
      end else begin
         sector = hsl_pkg::SECTOR_BLUE;  pos = red;   neg = green;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
      end
      if (enable) begin
         d1_ff   <= mx - mn;
         s1_ff   <= DW'(mx) + DW'(mn);
         sec1_ff <= sector;
         pos1_ff <= pos;
         neg1_ff <= neg;
      end
   end

   logic [DW-1:0]                    den, diff;
   logic [hsl_pkg::SAT_NUM_W-1:0]    sat_num;
   logic [hsl_pkg::HUE_NUM_W-1:0]    hue_num;
   logic [hsl_pkg::LEVEL_BITS:0]     light_x;

   always_comb begin
      den      = (s1_ff <= DW'(255)) ? s1_ff : DW'(510) - s1_ff;
      diff     = DW'(pos1_ff) + DW'(d1_ff) - DW'(neg1_ff);
      // round half up: (2*num + den) / (2*den)
      sat_num  = hsl_pkg::SAT_NUM_W'(d1_ff) * hsl_pkg::SAT_SCALE
                 + hsl_pkg::SAT_NUM_W'(den);
      hue_num  = hsl_pkg::HUE_NUM_W'(diff) * hsl_pkg::HUE_SCALE
                 + hsl_pkg::HUE_NUM_W'(d1_ff);
      // s*65535/510 is s*257/2 exactly
      light_x  = (hsl_pkg::LEVEL_BITS+1)'(s1_ff) * (hsl_pkg::LEVEL_BITS+1)'(257)
                 + (hsl_pkg::LEVEL_BITS+1)'(1);
      data2_in.grey    = (d1_ff == '0);
      data2_in.sector  = sec1_ff;
      data2_in.light   = light_x[hsl_pkg::LEVEL_BITS:1];
      data2_in.sat_den = data2_in.grey ? DW'(1) : {den[DW-2:0], 1'b0};
      data2_in.sat_rem = sat_num[hsl_pkg::SAT_NUM_W-1 -: DW];
      data2_in.sat_low = sat_num[hsl_pkg::DIV_STEPS-1:0];
      data2_in.hue_den = data2_in.grey ? DW'(2) : {d1_ff, 1'b0};
      data2_in.hue_rem = DW'(hue_num[hsl_pkg::HUE_NUM_W-1:hsl_pkg::DIV_STEPS]);
      data2_in.hue_low = hue_num[hsl_pkg::DIV_STEPS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (enable) begin
         v2_ff <= v1_ff;
      end
      if (enable) begin
         data2_ff <= data2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = data2_ff;

endmodule

[sv/hsl_div_step.sv]
// One registered restoring-division step for the saturation and hue dividers.
// Depends on hsl_pkg.
module hsl_div_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  hsl_pkg::div_type in_data,
   output logic             out_valid,
   output hsl_pkg::div_type out_data
);
   localparam int DW = hsl_pkg::DEN_W;
   localparam int LW = hsl_pkg::DIV_STEPS;

   logic             valid_ff;
   hsl_pkg::div_type data_ff, data_in;
   logic [DW:0]      sat_trial, hue_trial;
   logic             sat_fit, hue_fit;

   always_comb begin
      data_in   = in_data;
      sat_trial = {in_data.sat_rem, in_data.sat_low[LW-1]};
      hue_trial = {in_data.hue_rem, in_data.hue_low[LW-1]};
      sat_fit   = sat_trial >= {1'b0, in_data.sat_den};
      hue_fit   = hue_trial >= {1'b0, in_data.hue_den};
      data_in.sat_rem = sat_fit ? DW'(sat_trial - {1'b0, in_data.sat_den}) : sat_trial[DW-1:0];
      data_in.hue_rem = hue_fit ? DW'(hue_trial - {1'b0, in_data.hue_den}) : hue_trial[DW-1:0];
      data_in.sat_low = {in_data.sat_low[LW-2:0], sat_fit};
      data_in.hue_low = {in_data.hue_low[LW-2:0], hue_fit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[sv/rgb_to_hsl_converter.sv]
// Top level of the RGB to HSL converter: front end, divider chain, output stage.
// Depends on hsl_pkg, hsl_front and hsl_div_step.
//
//   channel  direction  tdata fields (lowest bit up)
//   req      in         red_level[7:0], green_level[15:8], blue_level[23:16]
//   rsp      out        hue_angle[14:0], saturation_level[30:15],
//                       lightness_level[46:31], zero[47]
//
// One pixel enters per cycle while the output is not stalled; its result passes through two
// front stages, sixteen one-bit divider stages and one output stage.
// The latency is set by the 16 quotient bits of the saturation divider.
// Reset clears every stage's valid bit; payload registers are not reset.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
module rgb_to_hsl_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red_level, green_level, blue_level
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // hue_angle, saturation_level, lightness_level
);
   localparam int STEPS = hsl_pkg::DIV_STEPS;
   localparam int HW    = hsl_pkg::HUE_W;
   localparam int LB    = hsl_pkg::LEVEL_BITS;

   logic             advance;
   logic             stage_valid [STEPS+1];
   hsl_pkg::div_type stage_data  [STEPS+1];

   // advance every stage when the output register is free or being drained
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   hsl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (req_tvalid),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .out_valid (stage_valid[0]),
      .out_data  (stage_data[0])
   );

   // one quotient bit per stage for both dividers
   for (genvar i = 0; i < STEPS; i++) begin : g_div
      hsl_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (stage_valid[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   hsl_pkg::div_type last;
   logic [HW-1:0]    t_val, hue_in;
   logic [LB-1:0]    sat_in;
   logic             valid_ff;
   logic [HW-1:0]    hue_ff;
   logic [LB-1:0]    sat_ff, light_ff;

   // map the offset quotient t = round(U*(pos+d-neg)/d) onto the hue circle
   always_comb begin
      last  = stage_data[STEPS];
      t_val = last.hue_low[HW-1:0];
      case (last.sector)
         hsl_pkg::SECTOR_RED: begin
            if (t_val < hsl_pkg::SECTOR_UNITS) begin
               hue_in = t_val + hsl_pkg::HUE_FIVE_U;
            end else begin
               hue_in = t_val - hsl_pkg::SECTOR_UNITS;
            end
         end
         hsl_pkg::SECTOR_GREEN: hue_in = t_val + hsl_pkg::SECTOR_UNITS;
         hsl_pkg::SECTOR_BLUE:  hue_in = t_val + hsl_pkg::HUE_THREE_U;
         default:               hue_in = '0;
      endcase
      sat_in = last.sat_low;
      if (last.grey) begin
         hue_in = '0;
         sat_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_valid[STEPS];
      end
      if (advance) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         light_ff <= last.light;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, light_ff, sat_ff, hue_ff};

`ifndef NO_ASSERTIONS
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hue_ff < HW'(hsl_pkg::HUE_TWO_U * 3)))
      else $error("hue out of range");
   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && sat_ff == '0) |-> (hue_ff == '0))
      else $error("grey pixel with nonzero hue");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (stage_valid[STEPS] && advance) |=> rsp_tvalid)
      else $error("result dropped at output stage");
`endif

endmodule

[test/tb_rgb_to_hsl_converter.sv]
// Testbench for the RGB to HSL converter: streams pixels through the block and checks
// hue, saturation and lightness against a predictor held in this file.
// Depends on rgb_to_hsl_converter only.
`timescale 1ns / 1ps

module tb_rgb_to_hsl_converter;

   localparam int U = 60 << 6;        // one 60-degree sector in 1/64 degree
   localparam int FULL = 65535;       // 1.0 in level units
   localparam int LATENCY = 19;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct {
      logic [14:0] hue;
      logic [15:0] sat;
      logic [15:0] light;
   } hsl_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;     // red_level, green_level, blue_level
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // hue_angle, saturation_level, lightness_level

   pixel_type pixel_queue[$];
   hsl_type   hsl_expected[$];
   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;
   bit     hold_sender = 1'b0;
   bit     req_taken = 1'b0;
   int     errors = 0;
   int     pixels_sent = 0;
   int     results_seen = 0;

   rgb_to_hsl_converter dut (.*);

   always #4 clock = ~clock;

   // Round half up, exact in integers.
   function automatic longint round_div(longint num, longint den);
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic hsl_type convert_pixel(pixel_type p);
      hsl_type o;
      longint r, g, b, mx, mn, d, s, den, pos, neg, t, base;
      r = p.red; g = p.green; b = p.blue;
      mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
      mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
      d = mx - mn;
      s = mx + mn;
      o.light = 16'(round_div(s * FULL, 510));
      o.hue = '0;
      o.sat = '0;
      if (d != 0) begin
         den = (s <= 255) ? s : 510 - s;
         o.sat = 16'(round_div(d * FULL, den));
         // red wins ties, then green
         if (r == mx) begin
            base = 0; pos = g; neg = b;
         end else if (g == mx) begin
            base = 2; pos = b; neg = r;
         end else begin
            base = 4; pos = r; neg = g;
         end
         t = round_div(U * (pos + d - neg), d);
         // wrap a negative red-sector hue round by a full turn
         if (base == 0 && t < U) o.hue = 15'(t + 5 * U);
         else o.hue = 15'(base * U + t - U);
      end
      return o;
   endfunction

   // Driver: change inputs at the falling edge; hold the transfer until accepted.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_taken) begin
            // hold current item
         end else if (pixel_queue.size() != 0 && !hold_sender &&
                      $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pixel_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Record expectations for accepted pixels at the rising edge.
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         hsl_expected.push_back(convert_pixel(pixel_type'(req_tdata)));
         pixels_sent++;
      end
   end

   // Monitor: compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      hsl_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (hsl_expected.size() == 0) begin
            $error("unexpected result %h", rsp_tdata);
            errors++;
         end else begin
            want = hsl_expected.pop_front();
            if (rsp_tdata[14:0] !== want.hue) begin
               $error("hue_angle: expected %0d, got %0d", want.hue, rsp_tdata[14:0]);
               errors++;
            end
            if (rsp_tdata[30:15] !== want.sat) begin
               $error("saturation_level: expected %0d, got %0d", want.sat, rsp_tdata[30:15]);
               errors++;
            end
            if (rsp_tdata[46:31] !== want.light) begin
               $error("lightness_level: expected %0d, got %0d", want.light,
                      rsp_tdata[46:31]);
               errors++;
            end
         end
      end
   end

   task automatic add_pixel(int r, int g, int b);
      pixel_queue.push_back('{blue: 8'(b), green: 8'(g), red: 8'(r)});
   endtask

   task automatic drain_queue();
      while (pixel_queue.size() != 0 || req_tvalid) @(posedge clock);
   endtask

   task automatic add_random(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(9);
         // mostly uniform; some greys, ties and near-extreme pixels
         if (k == 0) begin
            k = $urandom_range(255);
            add_pixel(k, k, k);
         end else if (k == 1) begin
            k = $urandom_range(255);
            add_pixel(k, k, $urandom_range(255));
         end else if (k == 2) begin
            k = $urandom_range(255);
            add_pixel($urandom_range(255), k, k);
         end else if (k == 3) begin
            add_pixel($urandom_range(1) * 255, $urandom_range(1) * 255,
                      $urandom_range(255));
         end else begin
            add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: greys, primaries, ties, red-sector wrap, bright/dark extremes.
      add_pixel(0, 0, 0);       add_pixel(255, 255, 255); add_pixel(128, 128, 128);
      add_pixel(255, 0, 0);     add_pixel(0, 255, 0);     add_pixel(0, 0, 255);
      add_pixel(255, 255, 0);   add_pixel(0, 255, 255);   add_pixel(255, 0, 255);
      add_pixel(255, 0, 1);     add_pixel(255, 1, 0);     add_pixel(200, 10, 100);
      add_pixel(10, 200, 100);  add_pixel(100, 10, 200);  add_pixel(1, 0, 0);
      add_pixel(255, 254, 254); add_pixel(170, 85, 85);   add_pixel(127, 128, 128);
      add_pixel(128, 127, 127); add_pixel(0, 1, 1);       add_pixel(85, 170, 170);
      drain_queue();

      // Phases: free running, sender idle, receiver stalling, both.
      add_random(225); drain_queue();
      // pause the sender until every result is home
      hold_sender = 1'b1;
      while (hsl_expected.size() != 0) @(posedge clock);
      hold_sender = 1'b0;
      send_idle_pct = 86; add_random(225); drain_queue();
      send_idle_pct = 0; recv_stall_pct = 86; add_random(225); drain_queue();
      send_idle_pct = 36; recv_stall_pct = 36; add_random(225); drain_queue();
      send_idle_pct = 0; recv_stall_pct = 0;

      while (hsl_expected.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);

      $display("Covered %0d pixels and %0d results over four idling phases,",
               pixels_sent, results_seen);
      $display("including grey, tied-channel and red-sector wrap cases.");
      if (errors == 0 && hsl_expected.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: give up well beyond the slowest legitimate run.
   initial begin
      #2ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
